/* rtl/pf16_pkg.sv */
// Shared types and constants for the float-to-PCM16 block with statistics.
// No dependencies.
`default_nettype none
package pf16_pkg;
  localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
  localparam logic        CMD_CONVERT = 1'b0;
  localparam logic        CMD_CLEAR   = 1'b1;

  typedef struct packed {
    logic              clear;
    logic signed [15:0] pcm;
    logic              clip;
  } pf16_item_t;

  // FNV-1a step: (h ^ b) * 0x100000001b3 = (x << 40) + shifts of 0x1b3.
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
             + (x << 1) + x;
  endfunction
endpackage
`default_nettype wire

/* rtl/pf16_if.sv */
// Valid/ready channel interface carrying the block's payloads.
// Depends on nothing.
`default_nettype none
interface pf16_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] sample_bits;
  modport source (output valid, cmd, sample_bits, input ready);
  modport sink   (input valid, cmd, sample_bits, output ready);
endinterface

interface pf16_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_out;
  logic               clipped;
  logic [31:0]        clip_total;
  logic [63:0]        hash_value;
  logic [31:0]        sample_total;
  logic [15:0]        peak_magnitude;
  logic [63:0]        square_total;
  modport source (output valid, pcm_out, clipped, clip_total, hash_value, sample_total,
                  peak_magnitude, square_total, input ready);
  modport sink   (input valid, pcm_out, clipped, clip_total, hash_value, sample_total,
                  peak_magnitude, square_total, output ready);
endinterface
`default_nettype wire

/* rtl/pf16_front.sv */
// Front end: single-precision scale by 32767, round-to-even and saturation.
// Depends on pf16_pkg.
`default_nettype none
module pf16_front (
  input  wire logic           clk,
  input  wire logic           rst,
  pf16_in_if.sink             in_ch,
  output pf16_pkg::pf16_item_t item,
  output logic                item_valid,
  input  wire logic           item_ready
);
  // Stage 1 registers: 24x15 mantissa product and exponent.
  logic        s1_valid, s1_clear, s1_nan, s1_inf, s1_zero, s1_sign;
  logic [38:0] s1_prod;
  logic [8:0]  s1_exp;

  logic [7:0]  e_in;
  logic [23:0] m_in;
  logic        stall;

  assign stall = item_valid && !item_ready;
  assign in_ch.ready = !(s1_valid && stall);
  assign e_in = in_ch.sample_bits[30:23];
  assign m_in = (e_in == 8'd0) ? {1'b0, in_ch.sample_bits[22:0]}
                               : {1'b1, in_ch.sample_bits[22:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!(s1_valid && stall)) begin
      s1_valid <= in_ch.valid;
    end
    if (!(s1_valid && stall)) begin
      s1_clear <= in_ch.cmd == pf16_pkg::CMD_CLEAR;
      s1_sign  <= in_ch.sample_bits[31];
      s1_nan   <= (e_in == 8'hff) && (in_ch.sample_bits[22:0] != 23'd0);
      s1_inf   <= (e_in == 8'hff) && (in_ch.sample_bits[22:0] == 23'd0);
      s1_zero  <= (e_in == 8'd0) && (in_ch.sample_bits[22:0] == 23'd0);
      s1_prod  <= m_in * 39'd32767;
      s1_exp   <= (e_in == 8'd0) ? 9'd1 : {1'b0, e_in};
    end
  end

  // Stage 2: normalise and round the product to 24 bits (the float result),
  // then round that to an integer with ties to even. Value = prod * 2^(exp-150).
  logic [5:0]  lead;
  logic [38:0] norm;
  logic [23:0] mant;
  logic        g, st, up;
  logic [24:0] mant_r;
  logic signed [10:0] fexp;    // value = mant_r * 2^fexp
  logic [16:0] mag;
  logic        rb, sb, tie_up;
  logic [16:0] ip;
  logic signed [16:0] res;
  logic        clip;
  logic [38:0] wide_m;
  logic [38:0] ip_w;
  logic        over;
  logic [5:0]  sh;

  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < 39; i++) if (s1_prod[i]) lead = 6'(i);
    norm = s1_prod << (6'd38 - lead);
    mant = norm[38:15];
    g  = norm[14];
    st = |norm[13:0];
    up = g && (st || mant[0]);
    mant_r = {1'b0, mant} + {24'd0, up};
    fexp = 11'(signed'({2'b0, s1_exp})) - 11'sd150 + 11'(signed'({5'b0, lead})) - 11'sd23;
    // Shift mant_r right by -fexp into integer with round bits.
    wide_m = {14'd0, mant_r};
    ip = 17'd0; ip_w = '0; over = 1'b0; rb = 1'b0; sb = 1'b0; sh = '0; clip = 1'b0;
    if (fexp >= 11'sd0) begin
      clip = 1'b1;
    end else if (fexp < -11'sd38) begin
      ip = 17'd0; rb = 1'b0; sb = 1'b1;
    end else begin
      sh = 6'(-fexp);
      ip_w = wide_m >> sh;
      // Anything at or above 65536 is far outside the 16-bit range.
      over = |ip_w[38:16];
      ip = ip_w[16:0];
      rb = wide_m[sh - 6'd1];
      sb = |(wide_m & ((39'd1 << (sh - 6'd1)) - 39'd1));
    end
    tie_up = rb && (sb || ip[0]);
    mag = ip + {16'd0, tie_up};
    res = '0;
    if (s1_nan) begin
      res = -17'sd32768; clip = 1'b1;
    end else if (s1_inf || clip || over) begin
      res = s1_sign ? -17'sd32768 : 17'sd32767; clip = 1'b1;
    end else if (s1_zero) begin
      res = '0;
    end else if (s1_sign) begin
      if (mag > 17'd32768) begin res = -17'sd32768; clip = 1'b1; end
      else res = -signed'(mag);
    end else begin
      if (mag > 17'd32767) begin res = 17'sd32767; clip = 1'b1; end
      else res = signed'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!stall) begin
      item_valid <= s1_valid;
    end
    if (!stall) begin
      item.clear <= s1_clear;
      item.pcm   <= s1_clear ? 16'sd0 : res[15:0];
      item.clip  <= s1_clear ? 1'b0 : clip;
    end
  end
endmodule
`default_nettype wire

/* rtl/pf16_back.sv */
// Back end: hash, counters, peak and sum of squares, with output register.
// Depends on pf16_pkg.
`default_nettype none
module pf16_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  pf16_pkg::pf16_item_t item,
  input  wire logic            item_valid,
  output logic                 item_ready,
  pf16_out_if.source           out_ch
);
  typedef enum logic [1:0] {ST_IDLE = 2'b01, ST_HASH = 2'b10} state_t;
  state_t state;
  logic [63:0] hash_acc, hash_mid;
  logic [31:0] clip_acc, count_acc;
  logic [15:0] peak_acc, mag, held_mag;
  logic [31:0] sq;
  logic [63:0] square_acc;
  logic signed [15:0] held_pcm;
  logic        held_clip;
  logic        out_load;

  assign mag = item.pcm[15] ? 16'(-item.pcm) : item.pcm;
  assign item_ready = (state == ST_IDLE) && !(out_ch.valid && !out_ch.ready);
  assign hash_mid = pf16_pkg::fnv_mul(hash_acc ^ {56'd0, item.pcm[7:0]});
  assign sq = held_mag * held_mag;
  // A result is loaded at the end of a conversion or when a clear is taken.
  assign out_load = (state == ST_HASH) || (item_valid && item_ready && item.clear);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; out_ch.valid <= 1'b0;
      hash_acc <= pf16_pkg::FNV_BASIS; clip_acc <= '0; count_acc <= '0;
      peak_acc <= '0; square_acc <= '0;
    end else begin
      if (out_load) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (item_valid && item_ready) begin
            if (item.clear) begin
              hash_acc <= pf16_pkg::FNV_BASIS; clip_acc <= '0; count_acc <= '0;
              peak_acc <= '0; square_acc <= '0;
              out_ch.pcm_out <= '0; out_ch.clipped <= 1'b0;
              out_ch.clip_total <= '0; out_ch.hash_value <= pf16_pkg::FNV_BASIS;
              out_ch.sample_total <= '0; out_ch.peak_magnitude <= '0;
              out_ch.square_total <= '0;
            end else begin
              hash_acc <= hash_mid;
              held_pcm <= item.pcm; held_clip <= item.clip; held_mag <= mag;
              state <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          hash_acc <= pf16_pkg::fnv_mul(hash_acc ^ {56'd0, held_pcm[15:8]});
          clip_acc <= clip_acc + {31'd0, held_clip};
          count_acc <= count_acc + 32'd1;
          if (held_mag > peak_acc) peak_acc <= held_mag;
          square_acc <= square_acc + {32'd0, sq};
          out_ch.pcm_out <= held_pcm; out_ch.clipped <= held_clip;
          out_ch.clip_total <= clip_acc + {31'd0, held_clip};
          out_ch.hash_value <= pf16_pkg::fnv_mul(hash_acc ^ {56'd0, held_pcm[15:8]});
          out_ch.sample_total <= count_acc + 32'd1;
          out_ch.peak_magnitude <= (held_mag > peak_acc) ? held_mag : peak_acc;
          out_ch.square_total <= square_acc + {32'd0, sq};
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hash_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == ST_HASH |=> state == ST_IDLE && out_ch.valid) else $error("hash step stuck");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result lost");
  a_peak_bound: assert property (@(posedge clk) disable iff (rst) peak_acc <= 16'd32768)
    else $error("peak out of range");
`endif
endmodule
`default_nettype wire

/* rtl/pcm_float_to_int16_with_stats_unit.sv */
// Top level of the float-to-PCM16 converter with running statistics.
// Depends on pf16_pkg, pf16_if, pf16_front and pf16_back.
`default_nettype none
// Each input transaction either converts one single-precision sample to signed
// 16 bits (scale by 32767, round to nearest even, saturate; NaN gives -32768)
// or clears all statistics. Every transaction yields exactly one result
// transaction carrying the sample, its clip flag and the running FNV-1a-style
// hash, sample count, clip count, peak magnitude and sum of squares. A two-stage
// front end does the floating-point work and feeds a one-entry register into
// the back end; the back end hashes a sample's two bytes in chained FNV steps,
// one when it takes the item and one in its hash state, and takes no new item
// while in that state or while an untaken result is held. A sample passes the
// stage-1, item, back-end held and output registers; a clear skips the held one.
module pcm_float_to_int16_with_stats_unit (
  input wire logic clk,
  input wire logic rst,
  pf16_in_if.sink     in_ch,
  pf16_out_if.source  out_ch
);
  pf16_pkg::pf16_item_t item;
  logic item_valid, item_ready;

  pf16_front u_front (.clk, .rst, .in_ch, .item, .item_valid, .item_ready);
  pf16_back  u_back  (.clk, .rst, .item, .item_valid, .item_ready, .out_ch);
endmodule
`default_nettype wire
